@@ rtl/core/uqp_pkg.sv @@
// uqp_pkg: shared types, codes and helper functions for the URL query parser.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package uqp_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_QSKIP  = 3'd1,
    PH_PSTART = 3'd2,
    PH_NAME   = 3'd3,
    PH_NSKIP  = 3'd4,
    PH_VALUE  = 3'd5,
    PH_PCT    = 3'd6,
    PH_VSKIP  = 3'd7
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] param_index;
    logic [7:0] data_byte;
    logic       last_of_run;
  } res_t;

  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

  // Lenient hex digit: anything outside 0-9 / a-f maps through the uppercase rule
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    else d = c - 8'h37;
    return d;
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [3:0] idx,
                                  input logic [7:0] data);
    res_t r;
    r.kind        = k;
    r.param_index = idx;
    r.data_byte   = data;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/uqp_ifs.sv @@
// uqp channel interfaces: input items, result items, config writes.
// Depends on uqp_pkg.
`timescale 1ns / 1ps

interface uqp_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_byte;
  modport source (output valid, op, char_byte, input ready);
  modport sink   (input valid, op, char_byte, output ready);
endinterface

interface uqp_res_if;
  logic                valid;
  logic                ready;
  uqp_pkg::kind_t      kind;
  logic [3:0]          param_index;
  logic [7:0]          data_byte;
  logic                last_of_run;
  modport source (output valid, kind, param_index, data_byte, last_of_run, input ready);
  modport sink   (input valid, kind, param_index, data_byte, last_of_run, output ready);
endinterface

interface uqp_cfg_if;
  logic valid;
  logic ready;
  logic query_mode;
  modport source (output valid, query_mode, input ready);
  modport sink   (input valid, query_mode, output ready);
endinterface

@@ rtl/core/url_query_param_parser.sv @@
// url_query_param_parser: top level of the URL query-string splitter.
// Depends on uqp_pkg, uqp_ifs and uqp_res_fifo.
`timescale 1ns / 1ps

// Splits a URL or form body into parameters, one string byte per item with an
// end item to close the string. Each input item is held in an input register,
// run through the combinational parse logic and gives zero to three results
// (name byte, value byte, parameter end, string done) that go into a 4-entry
// result queue. An item is taken every cycle as long as the queue holds at
// most one result, so a stream that yields at most one result per byte runs at
// one item per cycle; an item that gives two or three results holds up the
// input for each extra one, as the output port gives one result at a time.
// The first result of an item passes the input register and then the result
// queue before it is offered. Percent escapes decode leniently; '+' becomes a
// space. query_mode is sampled only at the first byte of a string; write it
// between strings. No clearing pass.
module url_query_param_parser #(
  parameter int MAX_PARAMS    = 15,
  parameter int MAX_NAME_LEN  = 15,
  parameter int MAX_VALUE_LEN = 199
) (
  input logic     clk,
  input logic     rst,
  uqp_item_if.sink   din,
  uqp_res_if.source  dout,
  uqp_cfg_if.sink    cfg
);
  import uqp_pkg::*;

  localparam int PW = $clog2(MAX_PARAMS + 1);
  localparam int NW = $clog2(MAX_NAME_LEN + 1);
  localparam int VW = $clog2(MAX_VALUE_LEN + 1);

  // config
  logic query_mode;

  // input register
  logic       inq_valid;
  logic       inq_op;
  logic [7:0] inq_byte;

  // parse state
  phase_t        phase, phase_next;
  logic [PW-1:0] pcnt, pcnt_next;
  logic [NW-1:0] nlen, nlen_next;
  logic [VW-1:0] vlen, vlen_next;
  logic [7:0]    acc, acc_next;
  logic [1:0]    dseen, dseen_next;

  // step outputs
  res_t       r [MAX_RESULTS];
  logic [1:0] n;
  logic       fire;
  logic       room;
  logic       q_valid;
  res_t       q_head;

  // step scratch
  phase_t        ph;
  logic          is_end;
  logic          do_after;
  logic          do_end;
  logic [3:0]    idx;
  logic [NW-1:0] nl;
  logic [VW-1:0] vl_inc;
  logic [7:0]    acc_new;

  assign fire     = inq_valid && room;
  assign din.ready = !inq_valid || fire;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_mode <= 1'b0;
    end else if (cfg.valid) begin
      query_mode <= cfg.query_mode;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      inq_valid <= 1'b1;
    end else if (fire) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      inq_op   <= din.op;
      inq_byte <= din.char_byte;
    end
  end

  // One item worth of parsing
  always_comb begin
    phase_next = phase;
    pcnt_next  = pcnt;
    nlen_next  = nlen;
    vlen_next  = vlen;
    acc_next   = acc;
    dseen_next = dseen;
    for (int i = 0; i < MAX_RESULTS; i++) r[i] = '0;
    n        = 2'd0;
    do_after = 1'b0;
    do_end   = 1'b0;
    ph       = phase;
    nl       = nlen;
    idx      = 4'(pcnt);
    is_end   = inq_op || (inq_byte == 8'd0);
    vl_inc   = vlen + 1'b1;
    acc_new  = {acc[3:0], 4'd0} + digit_of(inq_byte);

    if (is_end) begin
      // flush a cut-short escape, close an open parameter, then report count
      if (phase == PH_PCT) begin
        r[n] = mk_res(KIND_VALUE, idx, acc);
        n    = n + 2'd1;
      end
      if (phase >= PH_NAME) begin
        r[n]      = mk_res(KIND_END, idx, 8'd0);
        n         = n + 2'd1;
        pcnt_next = pcnt + 1'b1;
      end
      r[n]       = mk_res(KIND_DONE, 4'd0, 8'(pcnt_next));
      n          = n + 2'd1;
      phase_next = PH_START;
      pcnt_next  = '0;
      nlen_next  = '0;
      vlen_next  = '0;
      acc_next   = '0;
      dseen_next = '0;
    end else begin
      if (phase == PH_START) ph = query_mode ? PH_QSKIP : PH_PSTART;
      phase_next = ph;
      case (ph)
        PH_QSKIP: begin
          if (inq_byte == CH_QUESTION) phase_next = PH_PSTART;
        end
        PH_PSTART, PH_NAME: begin
          // past the parameter cap, bytes are dropped until string end
          if (!(ph == PH_PSTART && pcnt >= PW'(MAX_PARAMS))) begin
            if (ph == PH_PSTART) begin
              nl        = '0;
              vlen_next = '0;
            end
            phase_next = PH_NAME;
            nlen_next  = nl;
            if (is_name_char(inq_byte) && nl < NW'(MAX_NAME_LEN)) begin
              r[n]      = mk_res(KIND_NAME, idx, inq_byte);
              n         = n + 2'd1;
              nlen_next = nl + 1'b1;
            end else begin
              do_after = 1'b1;
            end
          end
        end
        PH_NSKIP: do_after = 1'b1;
        PH_VALUE: begin
          if (inq_byte == CH_AMP) begin
            do_end = 1'b1;
          end else if (inq_byte == CH_PERCENT) begin
            acc_next   = '0;
            dseen_next = '0;
            phase_next = PH_PCT;
          end else begin
            r[n]       = mk_res(KIND_VALUE, idx,
                                (inq_byte == CH_PLUS) ? CH_SPACE : inq_byte);
            n          = n + 2'd1;
            vlen_next  = vl_inc;
            phase_next = (vl_inc >= VW'(MAX_VALUE_LEN)) ? PH_VSKIP : PH_VALUE;
          end
        end
        PH_PCT: begin
          if (inq_byte == CH_AMP) begin
            r[n]      = mk_res(KIND_VALUE, idx, acc);
            n         = n + 2'd1;
            vlen_next = vl_inc;
            do_end    = 1'b1;
          end else begin
            acc_next   = acc_new;
            dseen_next = dseen + 2'd1;
            if (dseen != 2'd0) begin
              r[n]       = mk_res(KIND_VALUE, idx, acc_new);
              n          = n + 2'd1;
              vlen_next  = vl_inc;
              phase_next = (vl_inc >= VW'(MAX_VALUE_LEN)) ? PH_VSKIP : PH_VALUE;
            end
          end
        end
        default: begin
          if (inq_byte == CH_AMP) do_end = 1'b1;
        end
      endcase

      // leaving a name: '&' closes, '=' opens the value, else skip to either
      if (do_after) begin
        if (inq_byte == CH_AMP) begin
          do_end = 1'b1;
        end else if (inq_byte == CH_EQUAL) begin
          vlen_next  = '0;
          phase_next = PH_VALUE;
        end else begin
          phase_next = PH_NSKIP;
        end
      end

      if (do_end) begin
        r[n]       = mk_res(KIND_END, idx, 8'd0);
        n          = n + 2'd1;
        pcnt_next  = pcnt + 1'b1;
        phase_next = PH_PSTART;
      end
    end

    if (n != 2'd0) r[n - 2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      pcnt  <= '0;
      nlen  <= '0;
      vlen  <= '0;
      acc   <= '0;
      dseen <= '0;
    end else if (fire) begin
      phase <= phase_next;
      pcnt  <= pcnt_next;
      nlen  <= nlen_next;
      vlen  <= vlen_next;
      acc   <= acc_next;
      dseen <= dseen_next;
    end
  end

  // Result queue decouples the burst of up to three results from the port
  uqp_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_n    (n),
    .push_data (r),
    .pop       (q_valid && dout.ready),
    .room      (room),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign dout.valid       = q_valid;
  assign dout.kind        = q_head.kind;
  assign dout.param_index = q_head.param_index;
  assign dout.data_byte   = q_head.data_byte;
  assign dout.last_of_run = q_head.last_of_run;

endmodule

@@ rtl/core/uqp_res_fifo.sv @@
// uqp_res_fifo: 4-entry result queue, takes up to 3 results per cycle, gives 1.
// Depends on uqp_pkg.
`timescale 1ns / 1ps

module uqp_res_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [1:0]      push_n,
  input  uqp_pkg::res_t   push_data [uqp_pkg::MAX_RESULTS],
  input  logic            pop,
  output logic            room,
  output logic            valid,
  output uqp_pkg::res_t   head
);
  import uqp_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] count_next;
  logic [1:0]         n_in;

  assign n_in       = push ? push_n : 2'd0;
  assign count_next = count + FIFO_CW'(n_in) - FIFO_CW'(pop);
  assign valid      = (count != '0);
  assign room       = (count <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push && (2'(i) < push_n)) begin
        mem[wr_ptr + FIFO_AW'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(n_in);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count_next;
    end
  end

endmodule

@@ rtl/core/uqp_checker.sv @@
// uqp_checker: port-level assertions for url_query_param_parser, with bind.
// Depends on uqp_pkg and url_query_param_parser.
`timescale 1ns / 1ps

module uqp_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input uqp_pkg::kind_t out_kind,
  input logic [7:0]     out_data,
  input logic           out_last
);
  import uqp_pkg::*;

  // results stay offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // string done is always the final result of its end item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DONE |-> out_last)
    else $error("string done not last of run");

  // a parameter end always carries a zero data byte
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_END |-> out_data == 8'd0)
    else $error("parameter end carries data");

  a_name_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_NAME |-> out_data != 8'd0 && !out_data[7])
    else $error("bad name byte");

endmodule

bind url_query_param_parser uqp_checker u_uqp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_kind  (dout.kind),
  .out_data  (dout.data_byte),
  .out_last  (dout.last_of_run)
);

@@ tb/tb.sv @@
// tb: self-checking testbench for url_query_param_parser.
// Needs uqp_pkg, uqp_ifs and the parser RTL. Results are predicted item by item.
`timescale 1ns / 1ps

module tb;
  import uqp_pkg::*;

  // Sizes the block is built with; the predictor uses the same caps
  localparam int NAME_CAP  = 15;
  localparam int VALUE_CAP = 199;
  localparam int PARAM_CAP = 15;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Long receiver hold-off used to fill the block and stall its input
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst;

  uqp_item_if item_ch ();
  uqp_res_if  res_ch ();
  uqp_cfg_if  cfg_ch ();

  url_query_param_parser #(
    .MAX_PARAMS    (PARAM_CAP),
    .MAX_NAME_LEN  (NAME_CAP),
    .MAX_VALUE_LEN (VALUE_CAP)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (item_ch),
    .dout (res_ch),
    .cfg  (cfg_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser shadow state: mirrors the block's phase and counters
  // ---------------------------------------------------------------------------
  logic       mode_reg;
  phase_t     cur_phase;
  logic [7:0] param_cnt;
  int         name_len;
  int         value_len;
  logic [7:0] pct_acc;
  logic [1:0] pct_digits;

  res_t item_results[$];     // results of the item being parsed
  res_t pending_results[$];  // results still owed by the block, oldest first

  logic [7:0] str_buf[$];    // bytes of the string being built

  int fail_count = 0;
  bit gaps_on;
  bit stalls_on;
  int hold_token = 0;
  int rand_items;

  function automatic void clear_string_state();
    cur_phase  = PH_START;
    param_cnt  = 8'd0;
    name_len   = 0;
    value_len  = 0;
    pct_acc    = 8'd0;
    pct_digits = 2'd0;
  endfunction

  function automatic logic name_ok(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

  // Lenient hex: 0-9 and a-f as usual, everything else through the 'A' offset, mod 256
  function automatic logic [7:0] hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 8'd10;
    return c - 8'h41 + 8'd10;
  endfunction

  function automatic void add_result(kind_t k, logic [3:0] idx, logic [7:0] d);
    res_t r;
    r.kind        = k;
    r.param_index = idx;
    r.data_byte   = d;
    r.last_of_run = 1'b0;
    item_results.push_back(r);
  endfunction

  function automatic void close_param();
    add_result(KIND_END, param_cnt[3:0], 8'h00);
    param_cnt = param_cnt + 8'd1;
    cur_phase = PH_PSTART;
  endfunction

  function automatic void value_out(logic [7:0] d);
    add_result(KIND_VALUE, param_cnt[3:0], d);
    value_len++;
    cur_phase = (value_len >= VALUE_CAP) ? PH_VSKIP : PH_VALUE;
  endfunction

  // Name done or cut off: '&' closes, '=' opens the value, anything else skips
  function automatic void after_name(logic [7:0] c);
    if (c == CH_AMP) begin
      close_param();
    end else if (c == CH_EQUAL) begin
      value_len = 0;
      cur_phase = PH_VALUE;
    end else begin
      cur_phase = PH_NSKIP;
    end
  endfunction

  // Parse one accepted item and queue the results it causes
  function automatic void parse_item(logic op_i, logic [7:0] c);
    res_t r;
    bit   took_q;
    took_q = 1'b0;
    item_results.delete();
    if (op_i == OP_END || c == 8'h00) begin
      // a zero byte ends the string like an end item; open escape and param close first
      if (cur_phase == PH_PCT) add_result(KIND_VALUE, param_cnt[3:0], pct_acc);
      if (cur_phase >= PH_NAME) close_param();
      add_result(KIND_DONE, 4'd0, param_cnt);
      clear_string_state();
    end else begin
      if (cur_phase == PH_START) begin
        // query_mode is sampled here only
        cur_phase = mode_reg ? PH_QSKIP : PH_PSTART;
        if (mode_reg && c == CH_QUESTION) begin
          cur_phase = PH_PSTART;
          took_q    = 1'b1;
        end
      end
      if (!took_q) begin
        case (cur_phase)
          PH_QSKIP: begin
            if (c == CH_QUESTION) cur_phase = PH_PSTART;
          end
          PH_PSTART, PH_NAME: begin
            // past the parameter cap every byte is dropped until the end
            if (cur_phase == PH_NAME || param_cnt < PARAM_CAP) begin
              if (cur_phase == PH_PSTART) begin
                name_len  = 0;
                value_len = 0;
                cur_phase = PH_NAME;
              end
              if (name_ok(c) && name_len < NAME_CAP) begin
                add_result(KIND_NAME, param_cnt[3:0], c);
                name_len++;
              end else begin
                after_name(c);
              end
            end
          end
          PH_NSKIP: after_name(c);
          PH_VALUE: begin
            if (c == CH_AMP) begin
              close_param();
            end else if (c == CH_PLUS) begin
              value_out(CH_SPACE);
            end else if (c == CH_PERCENT) begin
              pct_acc    = 8'd0;
              pct_digits = 2'd0;
              cur_phase  = PH_PCT;
            end else begin
              value_out(c);
            end
          end
          PH_PCT: begin
            if (c == CH_AMP) begin
              // escape cut short: emit what has been gathered, no cap check
              add_result(KIND_VALUE, param_cnt[3:0], pct_acc);
              value_len++;
              close_param();
            end else begin
              pct_acc    = {pct_acc[3:0], 4'h0} + hex_val(c);
              pct_digits = pct_digits + 2'd1;
              if (pct_digits >= 2'd2) value_out(pct_acc);
            end
          end
          default: begin
            // value skip past the cap
            if (c == CH_AMP) close_param();
          end
        endcase
      end
    end
    if (item_results.size() > 0) begin
      r = item_results.pop_back();
      r.last_of_run = 1'b1;
      item_results.push_back(r);
    end
    foreach (item_results[i]) pending_results.push_back(item_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // valid stays high between back-to-back items; it drops only for a gap or in wait_idle
  task automatic send_item(input logic op_i, input logic [7:0] c);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.op        <= op_i;
    item_ch.char_byte <= c;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    parse_item(op_i, c);
  endtask

  task automatic send_string();
    foreach (str_buf[i]) send_item(OP_BYTE, str_buf[i]);
    str_buf.delete();
  endtask

  // End item, sometimes a zero byte instead
  task automatic end_string();
    if ($urandom_range(0, 9) == 0) send_item(OP_BYTE, 8'h00);
    else send_item(OP_END, 8'($urandom_range(0, 255)));
  endtask

  // Stop offering and let every owed result drain, plus the block's latency
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.query_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    mode_reg = m;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, the long hold-off, and the field compare
  // ---------------------------------------------------------------------------
  function automatic void cmp_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endfunction

  task automatic compare_result();
    res_t e;
    if (pending_results.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, actual kind %0d idx %0d data %h",
               $time, res_ch.kind, res_ch.param_index, res_ch.data_byte);
      return;
    end
    e = pending_results.pop_front();
    cmp_field("kind", 8'(e.kind), 8'(res_ch.kind));
    cmp_field("param_index", 8'(e.param_index), 8'(res_ch.param_index));
    cmp_field("data_byte", e.data_byte, res_ch.data_byte);
    cmp_field("last_of_run", 8'(e.last_of_run), 8'(res_ch.last_of_run));
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) compare_result();
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // String builders
  // ---------------------------------------------------------------------------
  function automatic void add_text(string s);
    foreach (s[i]) str_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h30 + 8'($urandom_range(0, 9));
      2, 3:    return 8'h41 + 8'($urandom_range(0, 25));
      4:       return CH_UNDER;
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // any value byte that has no meaning of its own
  function automatic logic [7:0] pick_value_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_AMP || c == CH_PERCENT || c == CH_PLUS);
    return c;
  endfunction

  function automatic logic [7:0] pick_hex_char();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h61 + 8'($urandom_range(0, 5));
      default: return 8'h41 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic void add_value(int len);
    int sel;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        str_buf.push_back(CH_PLUS);
      end else if (sel <= 2) begin
        str_buf.push_back(CH_PERCENT);
        str_buf.push_back(pick_hex_char());
        str_buf.push_back(pick_hex_char());
      end else if (sel == 3) begin
        // odd escape: any byte counts as a digit
        str_buf.push_back(CH_PERCENT);
        str_buf.push_back(pick_value_char());
      end else begin
        str_buf.push_back(pick_value_char());
      end
    end
  endfunction

  function automatic void add_param();
    int sel;
    int nlen;
    sel = $urandom_range(0, 9);
    if (sel != 0) begin
      nlen = (sel == 1) ? $urandom_range(0, NAME_CAP + 3) : $urandom_range(0, 5);
      for (int i = 0; i < nlen; i++) begin
        if ($urandom_range(0, 9) == 0) str_buf.push_back(8'($urandom_range(1, 255)));
        else str_buf.push_back(pick_name_char());
      end
      if ($urandom_range(0, 7) != 0) begin
        str_buf.push_back(CH_EQUAL);
        add_value($urandom_range(0, 6));
      end
    end
  endfunction

  // Mostly well-formed query strings; some pure noise
  function automatic void build_random_string();
    int np;
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) str_buf.push_back(8'($urandom_range(1, 255)));
    end else begin
      if (mode_reg) begin
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_QUESTION);
          str_buf.push_back(c);
        end
        if ($urandom_range(0, 7) != 0) str_buf.push_back(CH_QUESTION);
      end
      np = ($urandom_range(0, 9) == 0) ? $urandom_range(PARAM_CAP - 1, PARAM_CAP + 2)
                                       : $urandom_range(0, 4);
      for (int i = 0; i < np; i++) begin
        add_param();
        if (i < np - 1 || $urandom_range(0, 3) == 0) str_buf.push_back(CH_AMP);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_edge_cases();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    // empty first parameter, then an escape cut short by the end item
    add_text("&x=%4");
    send_string();
    send_item(OP_END, 8'hFF);
    // high byte never a name byte; escape cut short by '&'; zero byte ends it
    str_buf.push_back(8'hFF);
    add_text("=%&b");
    str_buf.push_back(8'h01);
    send_string();
    send_item(OP_BYTE, 8'h00);
    wait_idle();
  endtask

  task automatic test_query_mode();
    write_mode(1'b1);
    // '?' as the very first byte
    add_text("?a");
    send_string();
    send_item(OP_END, 8'h01);
    // no question mark: nothing comes out but the done item
    add_text("ab");
    send_string();
    send_item(OP_END, 8'h80);
    // mode flip in the middle of a string must not take effect
    write_mode(1'b0);
    add_text("k");
    send_string();
    write_mode(1'b1);
    add_text("=?");
    send_string();
    send_item(OP_END, 8'h00);
    wait_idle();
  endtask

  task automatic test_limits();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_mode(1'b0);
    // name longer than the cap
    for (int i = 0; i < NAME_CAP + 3; i++) str_buf.push_back(pick_name_char());
    add_text("=v");
    send_string();
    end_string();
    // value reaches the cap on a percent escape, rest of it is skipped
    add_text("v=");
    for (int i = 0; i < VALUE_CAP - 1; i++) str_buf.push_back(pick_value_char());
    add_text("%41xyz&w=1");
    send_string();
    end_string();
    // more parameters than the cap, each a one-byte name
    for (int i = 0; i < PARAM_CAP + 2; i++) begin
      str_buf.push_back(pick_name_char());
      str_buf.push_back(CH_AMP);
    end
    send_string();
    end_string();
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering: the result queue
  // fills and the input must stall without losing anything
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_mode(1'b0);
    hold_token <= hold_token + 1;
    add_text("k=");
    repeat (16) str_buf.push_back(pick_value_char());
    add_text("%4&z");
    send_string();
    end_string();
    wait_idle();
  endtask

  task automatic run_random_strings(input int n_items, input bit idle_on);
    gaps_on    = idle_on;
    stalls_on  = idle_on;
    rand_items = 0;
    while (rand_items < n_items) begin
      if (idle_on && $urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      build_random_string();
      rand_items += str_buf.size() + 1;
      send_string();
      end_string();
      // strings often run back to back; sometimes drain in between
      if (idle_on && $urandom_range(0, 2) == 0) wait_idle();
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_all
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.op        <= OP_BYTE;
    item_ch.char_byte <= 8'h00;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.query_mode <= 1'b0;
    mode_reg  = 1'b0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    clear_string_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_cases();
    test_query_mode();
    test_limits();
    test_backpressure();
    run_random_strings(20, 1'b1);
    // closing stretch runs with no idling on either side
    run_random_strings(20, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
